// File: rtl/phd_pkg.sv
// Shared constants, character codes and result type for the picture header detector.
package phd_pkg;

    // Default window length; the window holds one character less than this.
    localparam int WINDOW_LEN_DEF = 64;

    localparam int CHAR_W = 8;
    localparam int SIZE_W = 13;
    localparam int SPP_W  = 4;

    // Size limits and digit accumulator saturation value.
    localparam logic [SIZE_W-1:0] SIZE_MAX_OK = SIZE_W'(4095);
    localparam logic [SIZE_W-1:0] ACC_SAT     = SIZE_W'(4096);

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_Z_LOW  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_P_UP   = 8'h50;
    localparam logic [CHAR_W-1:0] CH_I_LOW  = 8'h69;
    localparam logic [CHAR_W-1:0] CH_C_LOW  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_X_LOW  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_C_UP   = 8'h43;
    localparam logic [CHAR_W-1:0] CH_P_LOW  = 8'h70;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_2      = 8'h32;
    localparam logic [CHAR_W-1:0] CH_4      = 8'h34;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;

    // Samples-per-pixel codes.
    localparam logic [SPP_W-1:0] SPP_NONE = 4'd0;
    localparam logic [SPP_W-1:0] SPP_2    = 4'd2;
    localparam logic [SPP_W-1:0] SPP_4    = 4'd4;
    localparam logic [SPP_W-1:0] SPP_8    = 4'd8;

    // Result of one window scan.
    typedef struct packed {
        logic              header_ok;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              is_colour;
        logic [SPP_W-1:0]  samples_per_pixel;
    } phd_result_t;

endpackage

// File: rtl/phd_digit_unit.sv
// Shared decimal digit accumulator: acc * 10 + digit, saturating.
module phd_digit_unit
    import phd_pkg::*;
(
    input  logic [SIZE_W-1:0] acc_in,
    input  logic [CHAR_W-1:0] digit_chr,
    output logic [SIZE_W-1:0] acc_out
);

    localparam int PROD_W = SIZE_W + 4;

    logic [PROD_W-1:0] acc_ext;
    logic [PROD_W-1:0] prod;

    // Times ten as two shifts and an add; the low nibble of a digit code is its value.
    assign acc_ext = {4'b0000, acc_in};
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(digit_chr[3:0]);

    // Clamp at the saturation value.
    assign acc_out = (prod > PROD_W'(ACC_SAT)) ? ACC_SAT : prod[SIZE_W-1:0];

endmodule

// File: rtl/phd_window.sv
// Circular character window with per-entry valid bits and a sequential read port.
module phd_window
    import phd_pkg::*;
#(
    parameter int WIN_CHARS = WINDOW_LEN_DEF - 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [CHAR_W-1:0] wr_char,
    input  logic              rd_start,
    input  logic              rd_en,
    output logic [CHAR_W-1:0] rd_char
);

    localparam int AW = $clog2(WIN_CHARS);
    localparam logic [AW-1:0] LAST = AW'(WIN_CHARS - 1);

    logic [CHAR_W-1:0]    mem [WIN_CHARS];
    logic [WIN_CHARS-1:0] vld_reg;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CHAR_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;

    // The head points at the oldest character, which a new one overwrites.
    always_comb begin
        head_next = head_reg;
        if (wr_en) begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
    end

    // A scan starts at the oldest character and walks forward with wrap.
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (rd_start) begin
            rd_ptr_next = head_reg;
        end else if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Pointers, valid bits and the registered valid of the read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            rd_ptr_reg <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            rd_ptr_reg <= rd_ptr_next;
            if (wr_en) begin
                vld_reg[head_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_ptr_reg];
            end
        end
    end

    // Character storage with one write and one registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[head_reg] <= wr_char;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Entries never written read as a space through their valid bits.
    assign rd_char = rd_vld_reg ? rd_data_reg : CH_SPACE;

endmodule

// File: rtl/phd_parser.sv
// Character-at-a-time sequencer that finds the header tag and parses the fields.
module phd_parser
    import phd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              tok_valid,
    input  logic              tok_end,
    input  logic [CHAR_W-1:0] tok_char,
    output logic              done,
    output phd_result_t       result
);

    typedef enum logic [2:0] {
        P_SEARCH,
        P_WIDTH,
        P_HEIGHT,
        P_TERM,
        P_SPEED,
        P_CLOSE,
        P_DONE
    } pstate_t;

    pstate_t             pstate_reg, pstate_next;
    logic [3*CHAR_W-1:0] hist_reg, hist_next;
    logic [SIZE_W-1:0]   width_reg, width_next;
    logic [SIZE_W-1:0]   height_reg, height_next;
    logic                col_reg, col_next;
    logic                ok_reg, ok_next;
    logic [SPP_W-1:0]    speed_reg, speed_next;

    logic [CHAR_W-1:0]   chr;
    logic                is_digit;
    logic                tag_hit;
    logic                sizes_ok;
    logic [SIZE_W-1:0]   acc_src;
    logic [SIZE_W-1:0]   acc_new;
    logic [SPP_W-1:0]    speed_map;

    // The end of the window reads as a NUL terminator.
    assign chr      = tok_end ? CH_NUL : tok_char;
    assign is_digit = (chr >= CH_0) && (chr <= CH_9);
    assign tag_hit  = (hist_reg == {CH_P_UP, CH_I_LOW, CH_C_LOW}) && (chr == CH_COLON);
    assign sizes_ok = (width_reg != '0) && (height_reg != '0) &&
                      (width_reg <= SIZE_MAX_OK) && (height_reg <= SIZE_MAX_OK);

    // One accumulator serves both size fields.
    assign acc_src = (pstate_reg == P_HEIGHT) ? height_reg : width_reg;

    phd_digit_unit u_digit (
        .acc_in    (acc_src),
        .digit_chr (chr),
        .acc_out   (acc_new)
    );

    // Speed character decode.
    always_comb begin
        case (chr)
            CH_4:    speed_map = SPP_4;
            CH_2:    speed_map = SPP_2;
            default: speed_map = SPP_8;
        endcase
    end

    // Parse step for one character.
    always_comb begin
        pstate_next = pstate_reg;
        hist_next   = hist_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        ok_next     = ok_reg;
        speed_next  = speed_reg;
        if (start) begin
            pstate_next = P_SEARCH;
            hist_next   = {3{CH_SPACE}};
            width_next  = '0;
            height_next = '0;
            col_next    = 1'b0;
            ok_next     = 1'b0;
        end else if (tok_valid) begin
            case (pstate_reg)
                P_SEARCH: begin
                    hist_next = {hist_reg[2*CHAR_W-1:0], chr};
                    if (tag_hit) begin
                        pstate_next = P_WIDTH;
                    end else if (tok_end) begin
                        pstate_next = P_DONE;
                    end
                end
                P_WIDTH: begin
                    if (is_digit) begin
                        width_next = acc_new;
                    end else if (chr == CH_X_LOW) begin
                        pstate_next = P_HEIGHT;
                    end else begin
                        pstate_next = P_DONE;
                    end
                end
                P_HEIGHT: begin
                    if (is_digit) begin
                        height_next = acc_new;
                    end else if (chr == CH_C_UP) begin
                        col_next    = 1'b1;
                        pstate_next = P_TERM;
                    end else if (chr == CH_SEMI) begin
                        ok_next     = sizes_ok;
                        if (sizes_ok) begin
                            speed_next = SPP_8;
                        end
                        pstate_next = P_DONE;
                    end else if (chr == CH_P_LOW) begin
                        pstate_next = P_SPEED;
                    end else begin
                        pstate_next = P_DONE;
                    end
                end
                P_TERM: begin
                    if (chr == CH_SEMI) begin
                        ok_next     = sizes_ok;
                        if (sizes_ok) begin
                            speed_next = SPP_8;
                        end
                        pstate_next = P_DONE;
                    end else if (chr == CH_P_LOW) begin
                        pstate_next = P_SPEED;
                    end else begin
                        pstate_next = P_DONE;
                    end
                end
                P_SPEED: begin
                    if (tok_end) begin
                        pstate_next = P_DONE;
                    end else begin
                        speed_next  = speed_map;
                        pstate_next = P_CLOSE;
                    end
                end
                P_CLOSE: begin
                    ok_next     = (chr == CH_SEMI) && sizes_ok;
                    pstate_next = P_DONE;
                end
                default: begin
                    pstate_next = P_DONE;
                end
            endcase
        end
    end

    // State and parse results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pstate_reg <= P_DONE;
            hist_reg   <= {3{CH_SPACE}};
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= 1'b0;
            ok_reg     <= 1'b0;
            speed_reg  <= SPP_NONE;
        end else begin
            pstate_reg <= pstate_next;
            hist_reg   <= hist_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            ok_reg     <= ok_next;
            speed_reg  <= speed_next;
        end
    end

    assign done                     = (pstate_reg == P_DONE);
    assign result.header_ok         = ok_reg;
    assign result.width             = width_reg;
    assign result.height            = height_reg;
    assign result.is_colour         = col_reg;
    assign result.samples_per_pixel = speed_reg;

endmodule

// File: rtl/picture_header_detector_unit.sv
// Each accepted character starts a scan that reads the window one character per cycle and
// feeds the header parser; a scan stops early once the header parse ends. The result is
// then loaded into the output register once that register is free. The input is not ready
// during a scan or while a result waits, so a new character waits for the last one's result.
// Reset (aresetn low, synchronous) empties the window to spaces at once through
// per-entry valid bits and clears the held samples-per-pixel value to zero.
module picture_header_detector_unit
    import phd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_header_ok,
    output logic [SIZE_W-1:0] m_width,
    output logic [SIZE_W-1:0] m_height,
    output logic              m_is_colour,
    output logic [SPP_W-1:0]  m_samples_per_pixel
);

    localparam int WIN_CHARS = WINDOW_LEN - 1;
    localparam int CW        = $clog2(WIN_CHARS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(WIN_CHARS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              end_sent_reg, end_sent_next;
    logic              tok_valid_reg, tok_valid_next;
    logic              tok_end_reg, tok_end_next;
    logic              m_valid_reg, m_valid_next;
    phd_result_t       out_reg, out_next;

    logic              in_xfer;
    logic              printable;
    logic              wr_en;
    logic              issue;
    logic              rd_en;
    logic              out_load;
    logic [CHAR_W-1:0] rd_char;
    logic              p_done;
    phd_result_t       p_result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign printable = (s_char_in >= CH_SPACE) && (s_char_in <= CH_Z_LOW);
    assign wr_en     = in_xfer && printable;

    // Issue one window position per cycle, then the end-of-window marker.
    assign issue    = (state_reg == ST_SCAN) && !end_sent_reg && !p_done;
    assign rd_en    = issue && (cnt_reg != CNT_END);
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    phd_window #(
        .WIN_CHARS (WIN_CHARS)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_char  (s_char_in),
        .rd_start (state_reg == ST_START),
        .rd_en    (rd_en),
        .rd_char  (rd_char)
    );

    phd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == ST_START),
        .tok_valid (tok_valid_reg),
        .tok_end   (tok_end_reg),
        .tok_char  (rd_char),
        .done      (p_done),
        .result    (p_result)
    );

    // Sequencer and output register next values.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        end_sent_next  = end_sent_reg;
        tok_valid_next = issue;
        tok_end_next   = issue && (cnt_reg == CNT_END);
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cnt_next      = '0;
                end_sent_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (p_done) begin
                    state_next = ST_HOLD;
                end else if (issue) begin
                    if (cnt_reg == CNT_END) begin
                        end_sent_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    out_next     = p_result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            end_sent_reg  <= 1'b0;
            tok_valid_reg <= 1'b0;
            tok_end_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            end_sent_reg  <= end_sent_next;
            tok_valid_reg <= tok_valid_next;
            tok_end_reg   <= tok_end_next;
            m_valid_reg   <= m_valid_next;
            out_reg       <= out_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_header_ok         = out_reg.header_ok;
    assign m_width             = out_reg.width;
    assign m_height            = out_reg.height;
    assign m_is_colour         = out_reg.is_colour;
    assign m_samples_per_pixel = out_reg.samples_per_pixel;

    // A valid header always carries sizes inside the allowed range.
    a_ok_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_header_ok) |->
            (m_width != '0 && m_width <= SIZE_MAX_OK &&
             m_height != '0 && m_height <= SIZE_MAX_OK))
        else $error("valid header reported with out-of-range size");

    // A valid header always leaves a nonzero speed behind.
    a_ok_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_header_ok) |-> (m_samples_per_pixel != SPP_NONE))
        else $error("valid header reported without a speed value");

    // The digit accumulators never pass the saturation value.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_width <= ACC_SAT && m_height <= ACC_SAT))
        else $error("size field above saturation value");

    // Every input transfer starts a scan in the following cycle.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_START))
        else $error("input transfer did not start a scan");

endmodule
